// File: rtl/lfr_pkg.sv
// shared types and codes for the led fade ramp controller
package lfr_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int LEVEL_BITS_DEF = 8;

    localparam int MODE_W  = 3;
    localparam int LEVEL_W = 8;
    localparam int DUR_W   = 16;

    localparam logic [MODE_W-1:0] MODE_ON     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FADE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd4;

    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_UNSUPPORTED = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] level_from;
        logic [LEVEL_W-1:0] level_to;
        logic [DUR_W-1:0]   duration_ms;
        logic [DUR_W-1:0]   elapsed_ms;
    } lfr_cmd_t;

    typedef struct packed {
        logic               status;
        logic               enable;
        logic [LEVEL_W-1:0] level;
    } lfr_rsp_t;

endpackage

// File: rtl/led_fade_ramp_controller_unit.sv
// led fade ramp controller: commands, serial step divider and serial ramp multiplier
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready, word cmd) takes one command or tick word at a
//   time; every accepted word returns exactly one rsp word (rsp_valid/rsp_ready)
//   with status, enable and the integer part of the brightness level.
//   On, off, toggle, unsupported codes, ticks while inactive and ticks with a
//   zero fade duration go straight to the write state once the word is taken.
//   A fade with a non-zero duration runs a restoring divider, one quotient bit
//   a cycle over LEVEL_W + FRAC_BITS bits.
//   An active tick runs a shift-add multiplier over elapsed_ms, one bit a cycle,
//   stopping once the remaining bits are zero.
//   One word is processed at a time; cmd_ready is high only when the block is
//   idle. The rsp register holds a finished word while the receiver stalls, and
//   the next cmd word is taken meanwhile; its result waits for the rsp slot.
//   Reset clears the output enable, all levels, the step and the duration, and
//   empties the rsp register.
module led_fade_ramp_controller_unit #(
    parameter int FRAC_BITS  = lfr_pkg::FRAC_BITS_DEF,
    parameter int LEVEL_BITS = lfr_pkg::LEVEL_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  lfr_pkg::lfr_cmd_t cmd,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output lfr_pkg::lfr_rsp_t rsp
);
    import lfr_pkg::*;

    localparam int FIX_BITS = LEVEL_BITS + FRAC_BITS;
    localparam int NUM_W    = LEVEL_W + FRAC_BITS;
    localparam int ACC_W    = FIX_BITS + DUR_W + 1;
    localparam int CNT_W    = $clog2(NUM_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic                 active_reg, active_next;
    logic [LEVEL_W-1:0]   start_reg, start_next;
    logic [LEVEL_W-1:0]   tgt_reg, tgt_next;
    logic [DUR_W-1:0]     dur_reg, dur_next;
    logic [FIX_BITS-1:0]  step_reg, step_next;
    logic [FIX_BITS-1:0]  cur_reg, cur_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    lfr_rsp_t             rsp_reg, rsp_next;
    logic                 status_reg, status_next;
    logic [DUR_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_W-1:0]     mcand_reg, mcand_next;
    logic [DUR_W-1:0]     mplier_reg, mplier_next;

    logic                 accept;
    logic [LEVEL_W-1:0]   lo_lvl, hi_lvl;
    logic [LEVEL_W-1:0]   diff_lvl;
    logic [FIX_BITS-1:0]  hi_fix, start_fix, tgt_fix;
    logic [DUR_W:0]       rem_try, rem_diff;
    logic                 q_bit;
    logic [NUM_W-1:0]     quo_shift;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // fade levels are stored low to high
    assign lo_lvl   = (cmd.level_from > cmd.level_to) ? cmd.level_to : cmd.level_from;
    assign hi_lvl   = (cmd.level_from > cmd.level_to) ? cmd.level_from : cmd.level_to;
    assign diff_lvl = hi_lvl - lo_lvl;

    assign hi_fix    = FIX_BITS'(hi_lvl) << FRAC_BITS;
    assign start_fix = FIX_BITS'(start_reg) << FRAC_BITS;
    assign tgt_fix   = FIX_BITS'(tgt_reg) << FRAC_BITS;

    // restoring divider step, quotient bits shift in where numerator bits leave
    assign rem_try   = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_try - {1'b0, dur_reg};
    assign q_bit     = (rem_try >= {1'b0, dur_reg});
    assign quo_shift = {quo_reg[NUM_W-2:0], q_bit};

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        start_next     = start_reg;
        tgt_next       = tgt_reg;
        dur_next       = dur_reg;
        step_next      = step_reg;
        cur_next       = cur_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        status_next    = status_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STATUS_OK;
                    state_next  = ST_WRITE;
                    unique case (cmd.mode)
                        MODE_ON:     active_next = 1'b1;
                        MODE_OFF:    active_next = 1'b0;
                        MODE_TOGGLE: active_next = !active_reg;
                        MODE_FADE:
                        begin
                            start_next = lo_lvl;
                            tgt_next   = hi_lvl;
                            dur_next   = cmd.duration_ms;
                            if (cmd.duration_ms == '0)
                            begin
                                cur_next  = hi_fix;
                                step_next = '0;
                            end
                            else
                            begin
                                rem_next   = '0;
                                quo_next   = {diff_lvl, {FRAC_BITS{1'b0}}};
                                cnt_next   = CNT_W'(NUM_W);
                                state_next = ST_DIV;
                            end
                        end
                        MODE_TICK:
                        begin
                            if (!active_reg)
                            begin
                                cur_next = start_fix;
                            end
                            else if (dur_reg == '0)
                            begin
                                cur_next = tgt_fix;
                            end
                            else
                            begin
                                acc_next    = ACC_W'(cur_reg);
                                mcand_next  = ACC_W'(step_reg);
                                mplier_next = cmd.elapsed_ms;
                                state_next  = ST_MUL;
                            end
                        end
                        default:     status_next = STATUS_UNSUPPORTED;
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_next = q_bit ? rem_diff[DUR_W-1:0] : rem_try[DUR_W-1:0];
                quo_next = quo_shift;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    step_next  = FIX_BITS'(quo_shift);
                    state_next = ST_WRITE;
                end
            end
            ST_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    // clamp at the target also covers saturation, target never tops the format
                    if ((step_reg != '0) && (acc_reg > ACC_W'(tgt_fix)))
                        cur_next = tgt_fix;
                    else
                        cur_next = acc_reg[FIX_BITS-1:0];
                    state_next = ST_WRITE;
                end
                else
                begin
                    if (mplier_reg[0])
                        acc_next = acc_reg + mcand_reg;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            ST_WRITE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status = status_reg;
                    rsp_next.enable = active_reg;
                    rsp_next.level  = cur_reg[FRAC_BITS +: LEVEL_W];
                    rsp_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            start_reg     <= '0;
            tgt_reg       <= '0;
            dur_reg       <= '0;
            step_reg      <= '0;
            cur_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            start_reg     <= start_next;
            tgt_reg       <= tgt_next;
            dur_reg       <= dur_next;
            step_reg      <= step_next;
            cur_reg       <= cur_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg    <= rsp_next;
        status_reg <= status_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    // divider never runs against a zero duration
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dur_reg != '0))
        else $error("divider running with zero duration");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("divider bit count ran out");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !cmd_ready)
        else $error("second word taken while one is in work");

    a_rsp_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("rsp word loaded outside the write state");

endmodule

// File: dv/tb_top.sv
// testbench for the led fade ramp controller: directed and random words, checked against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfr_pkg::*;

    localparam int FRAC  = FRAC_BITS_DEF;
    localparam int FIX_W = LEVEL_BITS_DEF + FRAC;
    localparam int SUM_W = FIX_W + DUR_W + 1;
    localparam logic [FIX_W-1:0] FIX_TOP = {FIX_W{1'b1}};
    localparam int RANDOM_WORDS = 800;
    localparam int DRAIN_LIMIT  = 200000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    lfr_cmd_t cmd = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    lfr_rsp_t rsp;

    // predictor state
    logic             lamp_on;
    logic [LEVEL_W-1:0] ramp_lo;
    logic [LEVEL_W-1:0] ramp_hi;
    logic [DUR_W-1:0] ramp_dur;
    logic [FIX_W-1:0] ramp_step;
    logic [FIX_W-1:0] lamp_level;

    lfr_rsp_t pending_rsp[$];
    int       mismatch_cnt = 0;
    int       rsp_seen = 0;
    int       mode_cnt[8];
    int       burst_left = 0;

    led_fade_ramp_controller_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d responses outstanding", pending_rsp.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic lfr_rsp_t lamp_predict(input lfr_cmd_t w);
        lfr_rsp_t         r;
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
        logic [FIX_W-1:0] span;
        logic [FIX_W-1:0] tgt;
        logic [SUM_W-1:0] sum;
        r.status = STATUS_OK;
        case (w.mode)
            MODE_ON:     lamp_on = 1'b1;
            MODE_OFF:    lamp_on = 1'b0;
            MODE_TOGGLE: lamp_on = !lamp_on;
            MODE_FADE:
            begin
                lo = (w.level_from > w.level_to) ? w.level_to : w.level_from;
                hi = (w.level_from > w.level_to) ? w.level_from : w.level_to;
                ramp_lo  = lo;
                ramp_hi  = hi;
                ramp_dur = w.duration_ms;
                if (w.duration_ms == '0)
                begin
                    lamp_level = FIX_W'(hi) << FRAC;
                    ramp_step  = '0;
                end
                else
                begin
                    span      = FIX_W'(hi - lo) << FRAC;
                    ramp_step = span / FIX_W'(w.duration_ms);
                end
            end
            MODE_TICK:
            begin
                tgt = FIX_W'(ramp_hi) << FRAC;
                if (!lamp_on)
                    lamp_level = FIX_W'(ramp_lo) << FRAC;
                else if (ramp_dur == '0)
                    lamp_level = tgt;
                else
                begin
                    sum = SUM_W'(lamp_level) + SUM_W'(ramp_step) * SUM_W'(w.elapsed_ms);
                    if (sum > SUM_W'(FIX_TOP))
                        sum = SUM_W'(FIX_TOP);
                    if (ramp_step != '0 && sum > SUM_W'(tgt))
                        sum = SUM_W'(tgt);
                    lamp_level = sum[FIX_W-1:0];
                end
            end
            default:     r.status = STATUS_UNSUPPORTED;
        endcase
        r.enable = lamp_on;
        r.level  = lamp_level[FRAC +: LEVEL_W];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // response checker, samples the pre-edge values at each rising edge
    always @(posedge clk)
    begin
        lfr_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_seen++;
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected response word", 1, 0);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", int'(rsp.status), int'(want.status));
                if (rsp.enable !== want.enable)
                    report_mismatch("enable", int'(rsp.enable), int'(want.enable));
                if (rsp.level !== want.level)
                    report_mismatch("level", int'(rsp.level), int'(want.level));
            end
        end
    end

    // receiver stall pattern: segments of always ready, coin flips and long stalls
    always @(posedge clk)
    begin
        int stall_kind;
        int seg_left;
        if (seg_left <= 0)
        begin
            stall_kind = $urandom_range(0, 2);
            seg_left   = $urandom_range(20, 200);
        end
        seg_left--;
        case (stall_kind)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // sends one word, then maybe idles the channel at the end of a burst
    task automatic send_word(input lfr_cmd_t w);
        int gap;
        cmd_valid <= 1'b1;
        cmd       <= w;
        do @(posedge clk); while (!cmd_ready);
        pending_rsp.push_back(lamp_predict(w));
        mode_cnt[w.mode]++;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    function automatic lfr_cmd_t make_word(input logic [MODE_W-1:0] m, input int from,
                                           input int to, input int dur, input int el);
        lfr_cmd_t w;
        w.mode        = m;
        w.level_from  = LEVEL_W'(from);
        w.level_to    = LEVEL_W'(to);
        w.duration_ms = DUR_W'(dur);
        w.elapsed_ms  = DUR_W'(el);
        return w;
    endfunction

    task automatic test_reset_tick();
        send_word(make_word(MODE_TICK, 0, 0, 0, 0));
    endtask

    task automatic test_unsupported();
        send_word(make_word(3'd5, 8'hFF, 8'h00, 16'hFFFF, 16'h0000));
        send_word(make_word(3'd6, 8'h00, 8'hFF, 16'h0000, 16'hFFFF));
        send_word(make_word(3'd7, 8'hAA, 8'h55, 16'hA5A5, 16'h5A5A));
    endtask

    task automatic test_power_cmds();
        send_word(make_word(MODE_ON, 8'h12, 8'h34, 16'h1234, 16'h5678));
        send_word(make_word(MODE_TOGGLE, 0, 0, 0, 0));
        send_word(make_word(MODE_TOGGLE, 0, 0, 0, 0));
        send_word(make_word(MODE_OFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_fade_ramp();
        // reversed levels with the longest duration
        send_word(make_word(MODE_FADE, 255, 0, 16'hFFFF, 0));
        send_word(make_word(MODE_ON, 0, 0, 0, 0));
        send_word(make_word(MODE_TICK, 0, 0, 0, 16'hFFFF));
        send_word(make_word(MODE_TICK, 0, 0, 0, 16'hFFFF));
        // steepest step drives the sum past the format top
        send_word(make_word(MODE_FADE, 0, 255, 1, 0));
        send_word(make_word(MODE_TICK, 0, 0, 0, 16'hFFFF));
        // equal levels: zero step leaves the level where it is
        send_word(make_word(MODE_FADE, 100, 100, 10, 0));
        send_word(make_word(MODE_TICK, 0, 0, 0, 500));
        // level above a new lower target gets pulled down
        send_word(make_word(MODE_FADE, 10, 50, 1000, 0));
        send_word(make_word(MODE_TICK, 0, 0, 0, 1));
        send_word(make_word(MODE_TICK, 0, 0, 0, 0));
    endtask

    task automatic test_fade_jump();
        send_word(make_word(MODE_FADE, 200, 30, 0, 0));
        send_word(make_word(MODE_TICK, 0, 0, 0, 77));
        send_word(make_word(MODE_OFF, 0, 0, 0, 0));
        send_word(make_word(MODE_TICK, 0, 0, 0, 3));
        send_word(make_word(MODE_FADE, 0, 0, 0, 0));
        send_word(make_word(MODE_TICK, 0, 0, 0, 16'hFFFF));
    endtask

    function automatic int pick_dur();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 16'hFFFF;
            2, 3:    return $urandom_range(0, 16'hFFFF);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    function automatic int pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 16'hFFFF;
            2:       return $urandom_range(0, 16'hFFFF);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    task automatic test_random();
        lfr_cmd_t w;
        int       r;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            w.mode        = MODE_W'($urandom_range(0, 7));
            w.level_from  = LEVEL_W'($urandom_range(0, 255));
            w.level_to    = ($urandom_range(0, 9) == 0) ? w.level_from
                                                        : LEVEL_W'($urandom_range(0, 255));
            w.duration_ms = DUR_W'(pick_dur());
            w.elapsed_ms  = DUR_W'(pick_elapsed());
            // mostly fades, power commands and ticks with random content
            r = $urandom_range(0, 99);
            if (r < 40)
                w.mode = MODE_TICK;
            else if (r < 60)
                w.mode = MODE_FADE;
            else if (r < 70)
                w.mode = MODE_ON;
            else if (r < 76)
                w.mode = MODE_OFF;
            else if (r < 84)
                w.mode = MODE_TOGGLE;
            send_word(w);
        end
    endtask

    initial
    begin
        int waited;
        lamp_on    = 1'b0;
        ramp_lo    = '0;
        ramp_hi    = '0;
        ramp_dur   = '0;
        ramp_step  = '0;
        lamp_level = '0;
        foreach (mode_cnt[k])
            mode_cnt[k] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_tick();
        test_unsupported();
        test_power_cmds();
        test_fade_ramp();
        test_fade_jump();
        test_random();

        cmd_valid <= 1'b0;
        waited = 0;
        while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_rsp.size() != 0)
            report_mismatch("responses never delivered", 0, pending_rsp.size());
        repeat (40) @(posedge clk);

        $display("words sent: on %0d, off %0d, toggle %0d, fade %0d, tick %0d, unsupported %0d",
                 mode_cnt[MODE_ON], mode_cnt[MODE_OFF], mode_cnt[MODE_TOGGLE],
                 mode_cnt[MODE_FADE], mode_cnt[MODE_TICK],
                 mode_cnt[5] + mode_cnt[6] + mode_cnt[7]);
        $display("responses checked: %0d, mismatches: %0d", rsp_seen, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/lfr_pkg.sv
rtl/led_fade_ramp_controller_unit.sv
dv/tb_top.sv
